/* hw/rtl/brb_pkg.sv */
// Package for the byte ring buffer chunk queue.
// Holds the shared widths, codes and the stage record type; no dependencies.
package brb_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_CHUNK_DEF = 8;

  localparam int QSIZE_W  = 11;
  localparam int LEN_W    = 4;
  localparam int DATA_W   = 64;
  localparam int FILL_W   = 10;
  localparam int LANE_W   = 3;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 11'd1024;

  // Register select taken from paddr bit 2.
  localparam logic REG_QSIZE = 1'b0;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_NO_ROOM  = 2'd1,
    CAUSE_TOO_LONG = 2'd2
  } cause_e;

  // Result record handed from the control stage to the output stage.
  typedef struct packed {
    logic              acc;
    cause_e            cause;
    logic              rd;
    logic [LANE_W-1:0] lane;
    logic [LEN_W-1:0]  len;
    logic [FILL_W-1:0] fill;
  } meta_t;

endpackage

/* hw/rtl/brb_bank.sv */
// One byte lane of the ring store: one write port and one registered read port.
// Uses no package items.
module brb_bank #(
  parameter int ROWS = 128
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [$clog2(ROWS)-1:0] waddr_i,
  input  logic [7:0]              wdata_i,
  input  logic                    re_i,
  input  logic [$clog2(ROWS)-1:0] raddr_i,
  output logic [7:0]              rdata_o
);

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/brb_ctrl.sv */
// Control stage: queue size register, fill count, lane pointers and the
// all-or-nothing decision for each chunk. Depends on brb_pkg.
module brb_ctrl import brb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int NB    = MAX_CHUNK_DEF,
  localparam int BD   = (DEPTH + NB - 1) / NB,
  localparam int RW   = $clog2(BD)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      action_i,
  input  logic [LEN_W-1:0]          chunk_length_i,
  input  logic [DATA_W-1:0]         write_data_i,
  input  logic                      cfg_we_i,
  input  logic [QSIZE_W-1:0]        cfg_wdata_i,
  output logic [QSIZE_W-1:0]        qsize_o,
  output meta_t                     meta_o,
  output logic [NB-1:0]             bank_we_o,
  output logic [NB-1:0][RW-1:0]     bank_waddr_o,
  output logic [NB-1:0][7:0]        bank_wdata_o,
  output logic [NB-1:0]             bank_re_o,
  output logic [NB-1:0][RW-1:0]     bank_raddr_o
);

  localparam int LW = (NB > 1) ? $clog2(NB) : 1;
  localparam int FW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = ((SW > QSIZE_W) ? SW : QSIZE_W) + 1;

  logic [QSIZE_W-1:0] qsize_q;
  logic [FW-1:0]      fill_q;
  logic [RW-1:0]      wr_row_q, rd_row_q;
  logic [LW-1:0]      wr_lane_q, rd_lane_q;

  logic [CW-1:0] qs, ring, fill_ext, len_ext, fill_nx;
  logic          too_long, is_read, ok_wr, ok_rd;
  cause_e        cause;

  logic [4:0]    wsum, rsum;
  logic          wcarry, rcarry;
  logic [7:0][7:0] wbytes;

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == RW'(BD - 1)) ? '0 : r + 1'b1;
  endfunction

  assign wbytes = write_data_i;

  always_comb begin
    qs       = CW'(qsize_q);
    fill_ext = CW'(fill_q);
    len_ext  = CW'(chunk_length_i);
    if (qs < CW'(2)) begin
      ring = CW'(2);
    end else if (qs > CW'(DEPTH)) begin
      ring = CW'(DEPTH);
    end else begin
      ring = qs;
    end
    too_long = chunk_length_i > LEN_W'(NB);
    is_read  = (action_i == ACT_READ);
    ok_wr    = !too_long && !is_read && ((fill_ext + len_ext) < ring);
    ok_rd    = !too_long && is_read && (fill_ext >= len_ext);
    if (too_long) begin
      cause = CAUSE_TOO_LONG;
    end else if (ok_wr || ok_rd) begin
      cause = CAUSE_NONE;
    end else begin
      cause = CAUSE_NO_ROOM;
    end
    if (ok_wr) begin
      fill_nx = fill_ext + len_ext;
    end else if (ok_rd) begin
      fill_nx = fill_ext - len_ext;
    end else begin
      fill_nx = fill_ext;
    end
  end

  // Pointers are a (row, lane) pair; a chunk of at most NB bytes crosses
  // at most one row boundary.
  assign wsum   = 5'(wr_lane_q) + 5'(chunk_length_i);
  assign rsum   = 5'(rd_lane_q) + 5'(chunk_length_i);
  assign wcarry = wsum >= 5'(NB);
  assign rcarry = rsum >= 5'(NB);

  for (genvar b = 0; b < NB; b++) begin : g_lane
    logic [4:0] woff;
    logic       wsame, rsame;
    assign wsame = 5'(b) >= 5'(wr_lane_q);
    assign rsame = 5'(b) >= 5'(rd_lane_q);
    assign woff  = wsame ? 5'(b) - 5'(wr_lane_q) : 5'(b) + 5'(NB) - 5'(wr_lane_q);
    assign bank_we_o[b]    = accept_i && ok_wr && (woff < 5'(chunk_length_i));
    assign bank_waddr_o[b] = wsame ? wr_row_q : row_inc(wr_row_q);
    assign bank_wdata_o[b] = wbytes[woff[2:0]];
    assign bank_re_o[b]    = accept_i && ok_rd;
    assign bank_raddr_o[b] = rsame ? rd_row_q : row_inc(rd_row_q);
  end

  always_comb begin
    meta_o.acc   = ok_wr || ok_rd;
    meta_o.cause = cause;
    meta_o.rd    = ok_rd;
    meta_o.lane  = LANE_W'(rd_lane_q);
    meta_o.len   = chunk_length_i;
    meta_o.fill  = fill_nx[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qsize_q   <= QSIZE_RESET;
      fill_q    <= '0;
      wr_row_q  <= '0;
      wr_lane_q <= '0;
      rd_row_q  <= '0;
      rd_lane_q <= '0;
    end else if (cfg_we_i) begin
      // A new queue size empties the queue.
      qsize_q   <= cfg_wdata_i;
      fill_q    <= '0;
      wr_row_q  <= '0;
      wr_lane_q <= '0;
      rd_row_q  <= '0;
      rd_lane_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_nx[FW-1:0];
      if (ok_wr) begin
        wr_lane_q <= wcarry ? LW'(wsum - 5'(NB)) : LW'(wsum);
        wr_row_q  <= wcarry ? row_inc(wr_row_q) : wr_row_q;
      end
      if (ok_rd) begin
        rd_lane_q <= rcarry ? LW'(rsum - 5'(NB)) : LW'(rsum);
        rd_row_q  <= rcarry ? row_inc(rd_row_q) : rd_row_q;
      end
    end
  end

  assign qsize_o = qsize_q;

endmodule

/* hw/rtl/brb_out.sv */
// Output stage: holds the result record while the bank reads complete,
// rotates the lanes into chunk order and drives the result register.
// Depends on brb_pkg.
module brb_out import brb_pkg::*; #(
  parameter int NB = MAX_CHUNK_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  meta_t              meta_i,
  input  logic [NB-1:0][7:0] bank_rdata_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output logic               accepted_o,
  output logic [1:0]         refuse_cause_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic [FILL_W-1:0]  fill_level_o
);

  localparam int LW = (NB > 1) ? $clog2(NB) : 1;

  logic              s1_v_q, out_v_q, adv;
  meta_t             s1_meta_q;
  logic [7:0][7:0]   rbytes;
  logic              acc_q;
  cause_e            cause_q;
  logic [DATA_W-1:0] rdata_q;
  logic [FILL_W-1:0] fill_q;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = !s1_v_q || adv;

  for (genvar i = 0; i < 8; i++) begin : g_byte
    if (i < NB) begin : g_live
      logic [4:0]    sum;
      logic [LW-1:0] idx;
      assign sum = 5'(s1_meta_q.lane) + 5'(i);
      assign idx = (sum >= 5'(NB)) ? LW'(sum - 5'(NB)) : LW'(sum);
      assign rbytes[i] = (s1_meta_q.rd && (LEN_W'(i) < s1_meta_q.len)) ?
                         bank_rdata_i[idx] : 8'h00;
    end else begin : g_zero
      assign rbytes[i] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_v_q <= accept_i;
      end
      if (adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_meta_q <= meta_i;
    end
    if (adv && s1_v_q) begin
      acc_q   <= s1_meta_q.acc;
      cause_q <= s1_meta_q.cause;
      rdata_q <= rbytes;
      fill_q  <= s1_meta_q.fill;
    end
  end

  assign out_valid_o    = out_v_q;
  assign accepted_o     = acc_q;
  assign refuse_cause_o = cause_q;
  assign read_data_o    = rdata_q;
  assign fill_level_o   = fill_q;

endmodule

/* hw/rtl/byte_ring_buffer_chunk_queue_top.sv */
// Top level of the byte ring buffer chunk queue.
// Instantiates brb_ctrl, one brb_bank per byte lane and brb_out; uses brb_pkg.
//
// Usage: each input beat on the in channel (valid/ready) carries an action,
// a chunk length and up to eight write bytes. Each input beat yields exactly
// one result beat on the out channel: accepted, refuse cause, read bytes and
// the fill level after the chunk. Transfers are all or nothing.
// The store is split into MAX_CHUNK byte-wide banks, so every lane of a
// chunk is written or read in the same cycle.
// Throughput: one beat per cycle while the receiver takes results. The bank
// read and the result record are registered in the bank-read stage when the
// input beat is taken; the result register then loads from that stage.
// The queue size register sits at APB address 0; writing it empties the
// queue. pready is always high.
// Reset empties the queue and sets the queue size to 1024; no clearing pass
// runs, so the block takes beats as soon as reset is released.
// When the receiver stalls, the result register holds and one more beat is
// taken into the bank-read stage; after that in_ready_o drops.
module byte_ring_buffer_chunk_queue_top import brb_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [LEN_W-1:0]   chunk_length_i,
  input  logic [DATA_W-1:0]  write_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [1:0]         refuse_cause_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic [FILL_W-1:0]  fill_level_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int NB = MAX_CHUNK;
  localparam int BD = (DEPTH + NB - 1) / NB;
  localparam int RW = $clog2(BD);

  logic                 accept, cfg_we;
  logic [QSIZE_W-1:0]   qsize;
  meta_t                meta;
  logic [NB-1:0]        bank_we, bank_re;
  logic [NB-1:0][RW-1:0] bank_waddr, bank_raddr;
  logic [NB-1:0][7:0]   bank_wdata, bank_rdata;

  assign accept = in_valid_i && in_ready_o;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_QSIZE);
  assign prdata = (paddr[2] == REG_QSIZE) ? PDATA_W'(qsize) : '0;

  brb_ctrl #(
    .DEPTH (DEPTH),
    .NB    (NB)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action_i),
    .chunk_length_i (chunk_length_i),
    .write_data_i   (write_data_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[QSIZE_W-1:0]),
    .qsize_o        (qsize),
    .meta_o         (meta),
    .bank_we_o      (bank_we),
    .bank_waddr_o   (bank_waddr),
    .bank_wdata_o   (bank_wdata),
    .bank_re_o      (bank_re),
    .bank_raddr_o   (bank_raddr)
  );

  for (genvar b = 0; b < NB; b++) begin : g_bank
    brb_bank #(
      .ROWS (BD)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .re_i    (bank_re[b]),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  brb_out #(
    .NB (NB)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .meta_i         (meta),
    .bank_rdata_i   (bank_rdata),
    .out_ready_i    (out_ready_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .accepted_o     (accepted_o),
    .refuse_cause_o (refuse_cause_o),
    .read_data_o    (read_data_o),
    .fill_level_o   (fill_level_o)
  );

endmodule

/* hw/rtl/brb_checker.sv */
// Port-level checker for the byte ring buffer chunk queue, with its bind.
// Depends on brb_pkg and attaches to byte_ring_buffer_chunk_queue_top.
module brb_checker import brb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               accepted_o,
  input logic [1:0]         refuse_cause_o,
  input logic [DATA_W-1:0]  read_data_o,
  input logic [FILL_W-1:0]  fill_level_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic               pready
);

  logic              has_prev_q;
  logic [FILL_W-1:0] prev_fill_q;

  // Fill level of the last delivered result since reset or any APB write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_prev_q  <= 1'b0;
      prev_fill_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      has_prev_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      has_prev_q  <= 1'b1;
      prev_fill_q <= fill_level_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(fill_level_o) && $stable(refuse_cause_o))
    else $error("result beat changed while stalled");

  a_acc_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (refuse_cause_o == CAUSE_NONE)))
    else $error("accepted flag disagrees with refuse cause");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> read_data_o == '0)
    else $error("refused beat carries read data");

  a_refused_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o && has_prev_q |-> fill_level_o == prev_fill_q)
    else $error("refused beat changed the fill level");

endmodule

bind byte_ring_buffer_chunk_queue_top brb_checker u_brb_checker (.*);
